@@ hw/rtl/bytebeat_sample_stream_macros.svh @@
// Assertion macros shared by the bytebeat sample stream RTL.
`ifndef BYTEBEAT_SAMPLE_STREAM_MACROS_SVH
`define BYTEBEAT_SAMPLE_STREAM_MACROS_SVH

// Check on every clock edge outside reset.
`define BBSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define BBSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hw/rtl/bbss_pkg.sv @@
// Types, constants and helper functions of the bytebeat sample stream.
`default_nettype none

package bbss_pkg;

  localparam int unsigned MAX_BURST_DEF = 64;
  localparam int unsigned CNT_W         = 13;  // holds a burst count up to 8191
  localparam int unsigned CMD_DEPTH_DEF = 2;
  localparam int unsigned RES_DEPTH     = 2;

  localparam logic [31:0] END_RESET  = 32'd1300000;
  localparam logic [11:0] DIV_A_NUM  = 12'd3000;
  localparam logic [21:0] DIV_B      = 22'd40000;
  localparam logic [31:0] RECIP3     = 32'hAAAAAAAB;  // ceil(2^33 / 3)
  localparam logic [14:0] RECIP40K   = 15'd26843;     // floor(2^30 / 40000)
  localparam logic [7:0]  TERM_A     = 8'd35;

  typedef enum logic [1:0] {
    OP_READ     = 2'd0,
    OP_SEEK_ABS = 2'd1,
    OP_SEEK_REL = 2'd2,
    OP_SEEK_END = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_MUL,
    BS_DIV3,
    BS_XY,
    BS_Q40,
    BS_FIX,
    BS_OUT
  } bst_e;

  typedef struct packed {
    op_e              op;
    logic [CNT_W-1:0] cnt;
    logic [31:0]      offset;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  sample;
    logic        last;
    logic        ended;
    logic        status;
    logic [31:0] position;
    logic [31:0] remaining;
  } res_t;

  // Multiplier digit picked by bits 17:16 of the position.
  function automatic logic [3:0] digit_of(input logic [1:0] sel);
    logic [3:0] d;
    case (sel)
      2'd0:    d = 4'd6;
      2'd1:    d = 4'd6;
      2'd2:    d = 4'd8;
      default: d = 4'd9;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bbss_fifo.sv @@
// Small register queue used for requests and for results.
`default_nettype none

module bbss_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bbss_front.sv @@
// Request front end: decodes the opcode and clamps the burst length.
`default_nettype none

module bbss_front
  import bbss_pkg::*;
#(
  parameter int unsigned MaxBurst = MAX_BURST_DEF
) (
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [6:0]  byte_count_i,
  input  wire logic [31:0] offset_i,
  input  wire logic        q_full_i,
  output logic             q_push_o,
  output cmd_t             cmd_o
);

  always_comb begin
    cmd_o.op     = op_e'(op_i);
    cmd_o.offset = offset_i;
    if (32'(byte_count_i) > 32'(MaxBurst)) begin
      cmd_o.cnt = CNT_W'(MaxBurst);
    end else begin
      cmd_o.cnt = CNT_W'(byte_count_i);
    end
  end

  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i;

endmodule

`default_nettype wire

@@ hw/rtl/bbss_div.sv @@
// Iterative 3000 / y divider, four quotient bits a cycle; keeps the quotient LSB.
`default_nettype none

module bbss_div
  import bbss_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [13:0] y_i,
  output logic             qlsb_o
);

  logic        busy_q, busy_d;
  logic [1:0]  step_q, step_d;
  logic [13:0] rem_q, rem_d;
  logic [11:0] num_q, num_d;
  logic [13:0] y_q;
  logic        lsb_q, lsb_d;

  always_comb begin
    logic [14:0] tmp;
    logic        qb;
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    num_d  = num_q;
    lsb_d  = lsb_q;
    tmp    = '0;
    qb     = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = 2'd0;
      rem_d  = '0;
      num_d  = DIV_A_NUM;
    end else if (busy_q) begin
      for (int k = 0; k < 4; k++) begin
        tmp = {rem_d, num_d[11]};
        num_d = {num_d[10:0], 1'b0};
        if (tmp >= {1'b0, y_q}) begin
          rem_d = 14'(tmp - {1'b0, y_q});
          qb    = 1'b1;
        end else begin
          rem_d = tmp[13:0];
          qb    = 1'b0;
        end
      end
      step_d = step_q + 2'd1;
      if (step_q == 2'd2) begin
        busy_d = 1'b0;
        lsb_d  = qb;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    lsb_q <= lsb_d;
    if (start_i) begin
      y_q <= y_i;
    end
  end

  assign qlsb_o = lsb_q;

endmodule

`default_nettype wire

@@ hw/rtl/bbss_back.sv @@
// Request back end: position register, seeks and the per-sample formula sequencer.
`default_nettype none

module bbss_back
  import bbss_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        cmd_empty_i,
  input  wire cmd_t        cmd_i,
  output logic             cmd_pop_o,
  input  wire logic        res_full_i,
  output logic             res_push_o,
  output res_t             res_o
);

  bst_e             state_q, state_d;
  logic [31:0]      pos_q, pos_d;
  logic [31:0]      end_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  res_t             res_q, res_d;
  logic [31:0]      mul_q, mul_d;
  logic [6:0]       x_q, x_d;
  logic [20:0]      p_q, p_d;
  logic [5:0]       q0_q, q0_d;
  logic             div_start, div_lsb;
  logic [13:0]      y;

  assign y = pos_q[13:0];

  bbss_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .y_i    (y),
    .qlsb_o (div_lsb)
  );

  always_comb begin
    logic [60:0] prod3;
    logic [35:0] prod40;
    logic [21:0] lim;
    logic        bump;
    logic [5:0]  b;
    logic [5:0]  c;
    logic [7:0]  a;
    state_d    = state_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    res_d      = res_q;
    mul_d      = mul_q;
    x_d        = x_q;
    p_d        = p_q;
    q0_d       = q0_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    div_start  = 1'b0;
    res_o      = res_q;
    prod3      = '0;
    prod40     = '0;
    lim        = '0;
    bump       = 1'b0;
    b          = '0;
    c          = '0;
    a          = '0;
    res_o.remaining = (res_q.position < end_q) ? end_q - res_q.position : 32'd0;

    unique case (state_q)
      BS_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o       = 1'b1;
          res_d.sample    = '0;
          res_d.last      = 1'b1;
          res_d.ended     = 1'b0;
          res_d.status    = 1'b0;
          res_d.position  = pos_q;
          res_d.remaining = '0;
          state_d         = BS_OUT;
          unique case (cmd_i.op)
            OP_READ: begin
              if (pos_q > end_q) begin
                res_d.ended = 1'b1;
              end else if (cmd_i.cnt == '0) begin
                // drop a read of zero samples: no result, position held
                state_d = BS_IDLE;
              end else begin
                cnt_d   = cmd_i.cnt;
                state_d = BS_MUL;
              end
            end
            OP_SEEK_ABS: res_d.position = cmd_i.offset;
            OP_SEEK_REL: res_d.position = pos_q + cmd_i.offset;
            OP_SEEK_END: res_d.status = 1'b1;
            default: ;
          endcase
        end
      end
      BS_MUL: begin
        mul_d     = pos_q * 32'(digit_of(pos_q[17:16]));
        div_start = 1'b1;
        state_d   = BS_DIV3;
      end
      BS_DIV3: begin
        // divide by 24: drop the low three bits, then multiply by the reciprocal of 3
        prod3   = 61'(mul_q[31:3]) * 61'(RECIP3);
        x_d     = prod3[39:33];
        state_d = BS_XY;
      end
      BS_XY: begin
        p_d     = 21'(x_q) * 21'(y);
        state_d = BS_Q40;
      end
      BS_Q40: begin
        prod40  = 36'(p_q) * 36'(RECIP40K);
        q0_d    = prod40[35:30];
        state_d = BS_FIX;
      end
      BS_FIX: begin
        // reciprocal estimate is low by at most one
        lim  = 22'(q0_q) * DIV_B + DIV_B;
        bump = ({1'b0, p_q} >= lim);
        b    = q0_q + 6'(bump);
        c    = (pos_q[13:8] ^ pos_q[15:10]) | pos_q[19:14] | x_q[5:0];
        a    = ((y != 14'd0) && div_lsb) ? TERM_A : 8'd0;
        res_d.sample   = a + 8'(b) + 8'(c);
        res_d.last     = (cnt_q == CNT_W'(1));
        res_d.ended    = 1'b0;
        res_d.status   = 1'b0;
        res_d.position = pos_q + 32'd1;
        state_d        = BS_OUT;
      end
      BS_OUT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          pos_d      = res_q.position;
          if (res_q.last) begin
            state_d = BS_IDLE;
          end else begin
            cnt_d   = cnt_q - CNT_W'(1);
            state_d = BS_MUL;
          end
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
      pos_q   <= '0;
      end_q   <= END_RESET;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        end_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    mul_q <= mul_d;
    x_q   <= x_d;
    p_q   <= p_d;
    q0_q  <= q0_d;
  end

endmodule

`default_nettype wire

@@ hw/rtl/bytebeat_sample_stream.sv @@
// Bytebeat sample stream: seek/read requests in, one result per sample, per seek or per ended read out.
// Path: a seek's result is registered in the back end and then pushed into the result queue; each
// sample of a read passes the states MUL, DIV3, XY, Q40, FIX and OUT before it is pushed.
// Flow: the back end takes the next request only once the last is done, and OUT waits while the result
// queue is full; the six-step sample sequencer runs the multiply chain and the 3000/y divider.
// Reset: asynchronous, position 0, end position 1300000, both queues empty.
`default_nettype none

`include "bytebeat_sample_stream_macros.svh"

module bytebeat_sample_stream
  import bbss_pkg::*;
#(
  parameter int unsigned MaxBurst = MAX_BURST_DEF,
  parameter int unsigned CmdDepth = CMD_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  op_i,
  input  wire logic [6:0]  byte_count_i,
  input  wire logic [31:0] offset_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       sample_o,
  output logic             last_o,
  output logic             ended_o,
  output logic             status_o,
  output logic [31:0]      position_o,
  output logic [31:0]      remaining_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i
);

  cmd_t cmd_in, cmd_out;
  res_t res_in, res_out;
  logic q_push, q_full, q_empty, q_pop;
  logic res_push, res_full;
  logic ended_ok, status_ok;

  bbss_front #(
    .MaxBurst(MaxBurst)
  ) u_front (
    .push_i      (push),
    .full_o      (full),
    .op_i        (op_i),
    .byte_count_i(byte_count_i),
    .offset_i    (offset_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .cmd_o       (cmd_in)
  );

  bbss_fifo #(
    .Width($bits(cmd_t)),
    .Depth(CmdDepth)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (cmd_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (cmd_out),
    .empty_o(q_empty)
  );

  assign cfg_ready_o = 1'b1;

  bbss_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .cmd_empty_i(q_empty),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (q_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  bbss_fifo #(
    .Width($bits(res_t)),
    .Depth(RES_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign sample_o    = res_out.sample;
  assign last_o      = res_out.last;
  assign ended_o     = res_out.ended;
  assign status_o    = res_out.status;
  assign position_o  = res_out.position;
  assign remaining_o = res_out.remaining;

  assign ended_ok  = res_in.last && (res_in.sample == 8'd0) && (res_in.remaining == 32'd0);
  assign status_ok = res_in.last && !res_in.ended && (res_in.sample == 8'd0);

  `BBSS_ASSERT(a_no_push_when_full, res_push |-> !res_full, "result pushed into a full queue")
  `BBSS_ASSERT(a_ended_shape, (res_push && res_in.ended) |-> ended_ok, "ended result malformed")
  `BBSS_ASSERT(a_status_shape, (res_push && res_in.status) |-> status_ok, "bad error status")
  `BBSS_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> empty, "result queue not empty after reset")

endmodule

`default_nettype wire

@@ tb/bytebeat_sample_stream_test.sv @@
// Self-checking testbench for the bytebeat sample stream: queued requests, predicted results.
module bytebeat_sample_stream_test
  import bbss_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BURST_LIMIT   = MAX_BURST_DEF;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned PHASE_ITEMS   = 100;

  typedef struct {
    op_e         op;
    logic [6:0]  count;
    logic [31:0] offset;
  } stream_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  op_i = OP_READ;
  logic [6:0]  byte_count_i = '0;
  logic [31:0] offset_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  sample_o;
  logic        last_o;
  logic        ended_o;
  logic        status_o;
  logic [31:0] position_o;
  logic [31:0] remaining_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  stream_req_t pending_requests[$];
  res_t        expected_results[$];
  stream_req_t cur_req;
  bit          req_taken = 1'b0;

  // Predictor state
  logic [31:0] play_pos = '0;
  logic [31:0] end_pos = END_RESET;

  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;
  int unsigned cfg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  bytebeat_sample_stream uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .op_i         (op_i),
    .byte_count_i (byte_count_i),
    .offset_i     (offset_i),
    .empty        (empty),
    .pop          (pop),
    .sample_o     (sample_o),
    .last_o       (last_o),
    .ended_o      (ended_o),
    .status_o     (status_o),
    .position_o   (position_o),
    .remaining_o  (remaining_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [7:0] bytebeat_sample(input logic [31:0] t);
    logic [31:0] y, d, x, a, b, c, sum;
    y = t & 32'd16383;
    case (t[17:16])
      2'd0, 2'd1: d = 32'd6;
      2'd2:       d = 32'd8;
      default:    d = 32'd9;
    endcase
    x = ((t * d) / 32'd24) & 32'd127;
    a = '0;
    if (y != 0) a = ((32'd3000 / y) & 32'd1) * 32'd35;
    b = (x * y) / 32'd40000;
    c = (((t >> 8) ^ (t >> 10)) | (t >> 14) | x) & 32'd63;
    sum = a + b + c;
    return sum[7:0];
  endfunction

  function automatic void add_result(input logic [7:0] smp, input logic lst,
                                     input logic ended, input logic status);
    res_t r;
    r.sample    = smp;
    r.last      = lst;
    r.ended     = ended;
    r.status    = status;
    r.position  = play_pos;
    r.remaining = (play_pos < end_pos) ? end_pos - play_pos : 32'd0;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_request(input stream_req_t rq);
    int unsigned n;
    logic [7:0]  smp;
    case (rq.op)
      OP_READ: begin
        if (play_pos > end_pos) begin
          add_result(8'd0, 1'b1, 1'b1, 1'b0);
        end else begin
          n = (rq.count > BURST_LIMIT) ? BURST_LIMIT : rq.count;
          for (int unsigned i = 0; i < n; i++) begin
            smp = bytebeat_sample(play_pos);
            play_pos = play_pos + 32'd1;
            add_result(smp, i + 1 == n, 1'b0, 1'b0);
          end
        end
      end
      OP_SEEK_ABS: begin
        play_pos = rq.offset;
        add_result(8'd0, 1'b1, 1'b0, 1'b0);
      end
      OP_SEEK_REL: begin
        play_pos = play_pos + rq.offset;
        add_result(8'd0, 1'b1, 1'b0, 1'b0);
      end
      default: add_result(8'd0, 1'b1, 1'b0, 1'b1);
    endcase
  endfunction

  task automatic compare_field(input string fld, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", fld, exp_v, act_v);
      mismatches++;
    end
  endtask

  task automatic check_result();
    res_t e;
    if (expected_results.size() == 0) begin
      $error("unexpected result: sample %0h position %0h", sample_o, position_o);
      mismatches++;
    end else begin
      e = expected_results.pop_front();
      compare_field("sample", 32'(e.sample), 32'(sample_o));
      compare_field("last", 32'(e.last), 32'(last_o));
      compare_field("ended", 32'(e.ended), 32'(ended_o));
      compare_field("status", 32'(e.status), 32'(status_o));
      compare_field("position", e.position, position_o);
      compare_field("remaining", e.remaining, remaining_o);
    end
  endtask

  // Request driver and result consumer: change inputs on the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni && (!push || req_taken)) begin
      req_taken = 1'b0;
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_req = pending_requests.pop_front();
        push         <= 1'b1;
        op_i         <= cur_req.op;
        byte_count_i <= cur_req.count;
        offset_i     <= cur_req.offset;
      end else begin
        push <= 1'b0;
      end
    end
    pop <= rst_ni && ($urandom_range(99) >= pop_stall_pct);
  end

  // Handshake monitor: sample everything on the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        predict_request(cur_req);
        req_taken = 1'b1;
      end
      if (pop && !empty) check_result();
      if (cfg_valid_i && cfg_ready_o) begin
        end_pos = cfg_data_i;
        cfg_writes++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic stream_req_t make_req(input op_e op, input logic [6:0] count,
                                           input logic [31:0] offset);
    stream_req_t rq;
    rq.op     = op;
    rq.count  = count;
    rq.offset = offset;
    return rq;
  endfunction

  function automatic stream_req_t random_request();
    stream_req_t rq;
    int unsigned pick;
    rq = make_req(OP_READ, 7'($urandom_range(127)), $urandom());
    pick = $urandom_range(99);
    if (pick < 52) begin
      pick = $urandom_range(99);
      if (pick < 3)       rq.count = 7'd0;
      else if (pick < 80) rq.count = 7'($urandom_range(1, 12));
      else if (pick < 95) rq.count = 7'($urandom_range(13, 64));
      else                rq.count = 7'($urandom_range(65, 127));
    end else if (pick < 70) begin
      rq.op = OP_SEEK_ABS;
      // aim at the end boundary, y wrap points, the top of the range, near zero, or anywhere
      case ($urandom_range(4))
        0:       rq.offset = end_pos - 32'($urandom_range(48)) + 32'd3;
        1:       rq.offset = ($urandom() & ~32'h3FFF) - 32'($urandom_range(6));
        2:       rq.offset = 32'hFFFF_FFFF - 32'($urandom_range(40));
        3:       rq.offset = 32'($urandom_range(2000));
        default: rq.offset = $urandom();
      endcase
    end else if (pick < 90) begin
      rq.op = OP_SEEK_REL;
      if ($urandom_range(1) == 0) rq.offset = 32'($urandom_range(600)) - 32'd300;
    end else begin
      rq.op = OP_SEEK_END;
    end
    return rq;
  endfunction

  // Hold until nothing is queued, in flight or expected, then let the block settle.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_requests.size() != 0 || push || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_end_position(input logic [31:0] value);
    int unsigned seen;
    seen = cfg_writes;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    while (cfg_writes == seen) @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests against the reset end position
    pending_requests.push_back(make_req(OP_READ, 7'd1, 32'd0));
    pending_requests.push_back(make_req(OP_READ, 7'd0, 32'hFFFF_FFFF));
    pending_requests.push_back(make_req(OP_READ, 7'd127, 32'd0));
    pending_requests.push_back(make_req(OP_SEEK_ABS, 7'd0, 32'd16382));
    pending_requests.push_back(make_req(OP_READ, 7'd4, 32'd0));
    pending_requests.push_back(make_req(OP_SEEK_ABS, 7'd127, 32'h0001_FFFF));
    pending_requests.push_back(make_req(OP_READ, 7'd2, 32'd0));
    pending_requests.push_back(make_req(OP_SEEK_ABS, 7'd0, 32'h0002_FFFE));
    pending_requests.push_back(make_req(OP_READ, 7'd4, 32'd0));
    pending_requests.push_back(make_req(OP_SEEK_ABS, 7'd0, END_RESET - 32'd1));
    pending_requests.push_back(make_req(OP_READ, 7'd3, 32'd0));
    pending_requests.push_back(make_req(OP_READ, 7'd2, 32'd0));
    pending_requests.push_back(make_req(OP_SEEK_REL, 7'd0, 32'hFFFF_FFFD));
    pending_requests.push_back(make_req(OP_SEEK_END, 7'd0, 32'd0));
    pending_requests.push_back(make_req(OP_SEEK_ABS, 7'd0, 32'hAAAA_AAAA));
    pending_requests.push_back(make_req(OP_SEEK_ABS, 7'd0, 32'h5555_5555));
    pending_requests.push_back(make_req(OP_READ, 7'd1, 32'd0));
    pending_requests.push_back(make_req(OP_SEEK_REL, 7'd0, 32'd0));
    pending_requests.push_back(make_req(OP_SEEK_ABS, 7'd0, 32'd0));
    wait_idle();

    // Wrap of the position past the top of the range
    write_end_position(32'hFFFF_FFFF);
    pending_requests.push_back(make_req(OP_SEEK_ABS, 7'd0, 32'hFFFF_FFFD));
    pending_requests.push_back(make_req(OP_READ, 7'd6, 32'd0));
    pending_requests.push_back(make_req(OP_SEEK_ABS, 7'd0, 32'hFFFF_FFFF));
    pending_requests.push_back(make_req(OP_READ, 7'd1, 32'd0));
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          pop_stall_pct = 0;
          write_end_position(32'($urandom_range(200000, 3000000)));
        end
        1: begin
          send_idle_pct = 84;
          pop_stall_pct = 0;
          write_end_position(32'hFFFF_FFFF);
        end
        2: begin
          send_idle_pct = 0;
          pop_stall_pct = 84;
          write_end_position(32'd0);
        end
        default: begin
          send_idle_pct = 31;
          pop_stall_pct = 31;
          write_end_position(END_RESET);
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold the sender until every pending result is back
        if (n == PHASE_ITEMS / 2) wait_idle();
        pending_requests.push_back(random_request());
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
